[hdl/rate_monotonic_tick_scheduler_top_defines.svh]
// Assertion macros for the checker file of the scheduler.
`ifndef RATE_MONOTONIC_TICK_SCHEDULER_TOP_DEFINES_SVH
`define RATE_MONOTONIC_TICK_SCHEDULER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RMTS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scheduler assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RMTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scheduler assertion failed");

`endif

[hdl/rmts_pkg.sv]
package rmts_pkg;

  localparam int unsigned DEF_NUM_TASKS = 4;
  localparam int unsigned DEF_TIME_BITS = 16;

  // Only four tasks can be set up through the configuration port.
  localparam int unsigned SETUP_TASKS = 4;

  localparam int unsigned FIELD_W    = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 48;
  localparam int unsigned ACTIVE_W   = 3;
  localparam int unsigned RUN_W      = 2;
  localparam int unsigned MASK_W     = 4;

  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 3'd4;
  localparam logic [FIELD_W-1:0]  SAT_MAX      = 16'hFFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACTIVE = 3'd0,
    REG_TASK0  = 3'd1,
    REG_TASK1  = 3'd2,
    REG_TASK2  = 3'd3,
    REG_TASK3  = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [RUN_W-1:0]   running_task;
    logic               cpu_idle;
    logic               preempted;
    logic               finished;
    logic [FIELD_W-1:0] finished_wait;
    logic [MASK_W-1:0]  missed_mask;
    logic               all_done;
    logic [FIELD_W-1:0] completions_total;
    logic [FIELD_W-1:0] misses_total;
  } res_t;

endpackage

[hdl/rmts_cfg.sv]
module rmts_cfg #(
  parameter int unsigned NUM_TASKS = rmts_pkg::DEF_NUM_TASKS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [rmts_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [rmts_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output logic [NUM_TASKS-1:0]               en_o,
  output logic [rmts_pkg::FIELD_W-1:0]       per_o [NUM_TASKS],
  output logic [rmts_pkg::FIELD_W-1:0]       exe_o [NUM_TASKS],
  output logic [rmts_pkg::FIELD_W-1:0]       cnt_o [NUM_TASKS]
);
  import rmts_pkg::*;

  localparam int unsigned SETUP_N = (NUM_TASKS < SETUP_TASKS) ? NUM_TASKS : SETUP_TASKS;

  logic [ACTIVE_W-1:0] active_q;
  logic                wr;

  assign cfg_ready_o = 1'b1;
  assign wr          = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= ACTIVE_RESET;
    end else if (wr && cfg_index_i == REG_ACTIVE) begin
      active_q <= cfg_data_i[ACTIVE_W-1:0];
    end
  end

  for (genvar t = 0; t < NUM_TASKS; t++) begin : g_task
    if (t < SETUP_N) begin : g_setup
      logic [CFG_DATA_W-1:0] setup_q;

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          setup_q <= '0;
        end else if (wr && cfg_index_i == CFG_IDX_W'(int'(REG_TASK0) + t)) begin
          setup_q <= cfg_data_i;
        end
      end

      assign per_o[t] = setup_q[FIELD_W-1:0];
      assign exe_o[t] = setup_q[2*FIELD_W-1:FIELD_W];
      assign cnt_o[t] = setup_q[3*FIELD_W-1:2*FIELD_W];
    end else begin : g_none
      assign per_o[t] = '0;
      assign exe_o[t] = '0;
      assign cnt_o[t] = '0;
    end

    // A task takes part when it lies below the active count and has a period.
    assign en_o[t] = (int'(active_q) > t) && (per_o[t] != '0);
  end

endmodule

[hdl/rmts_pick.sv]
module rmts_pick #(
  parameter int unsigned NUM_TASKS = rmts_pkg::DEF_NUM_TASKS,
  localparam int unsigned IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1
) (
  input  logic [NUM_TASKS-1:0]         ready_i,
  input  logic [rmts_pkg::FIELD_W-1:0] per_i [NUM_TASKS],
  output logic                         found_o,
  output logic [IDX_W-1:0]             idx_o
);
  import rmts_pkg::*;

  localparam int unsigned LEAVES = 1 << IDX_W;

  typedef struct packed {
    logic               vld;
    logic [FIELD_W-1:0] per;
    logic [IDX_W-1:0]   idx;
  } node_t;

  node_t node [1:2*LEAVES-1];

  // Tournament tree: the left child holds the lower indices, so it wins ties.
  always_comb begin
    for (int l = 0; l < LEAVES; l++) begin
      if (l < NUM_TASKS) begin
        node[LEAVES+l] = '{vld: ready_i[l], per: per_i[l], idx: IDX_W'(l)};
      end else begin
        node[LEAVES+l] = '{vld: 1'b0, per: '0, idx: IDX_W'(l)};
      end
    end
    for (int n = LEAVES - 1; n >= 1; n--) begin
      if (node[2*n].vld && (!node[2*n+1].vld || node[2*n].per <= node[2*n+1].per)) begin
        node[n] = node[2*n];
      end else begin
        node[n] = node[2*n+1];
      end
    end
  end

  assign found_o = node[1].vld;
  assign idx_o   = node[1].idx;

endmodule

[hdl/rate_monotonic_tick_scheduler_top.sv]
// Rate-monotonic tick scheduler for up to four periodic tasks.
// Configuration channel: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i.
// Index 0 sets the number of active tasks, indexes 1 to 4 the setup word of
// tasks 0 to 3 (period, execution time, job count). The port is always ready;
// write it only while no tick is in flight.
// Input channel: in_valid_i/in_stall_o carry one tick; advance_i = 1 moves the
// schedule on by one time unit, 0 only reports the current choice.
// Output channel: out_valid_o/out_stall_i carry one result per tick.
// One tick is accepted every cycle while in_stall_o is low. A tick is held in the
// input register; its whole per-tick update (release, shortest-period select and
// counter updates) is computed from there and written into the result register
// once the result register is empty or its result is being taken.
// While the receiver stalls, the result register holds its value and one more
// tick may wait in the input register; after that in_stall_o rises.
// Reset clears all task state, the totals and both pipeline stages, sets the
// active count to four and every setup word to zero.
module rate_monotonic_tick_scheduler_top #(
  parameter int unsigned NUM_TASKS = rmts_pkg::DEF_NUM_TASKS,
  parameter int unsigned TIME_BITS = rmts_pkg::DEF_TIME_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [rmts_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [rmts_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            advance_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [rmts_pkg::RUN_W-1:0]      running_task_o,
  output logic                            cpu_idle_o,
  output logic                            preempted_o,
  output logic                            finished_o,
  output logic [rmts_pkg::FIELD_W-1:0]    finished_wait_o,
  output logic [rmts_pkg::MASK_W-1:0]     missed_mask_o,
  output logic                            all_done_o,
  output logic [rmts_pkg::FIELD_W-1:0]    completions_total_o,
  output logic [rmts_pkg::FIELD_W-1:0]    misses_total_o
);
  import rmts_pkg::*;

  localparam int unsigned IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int unsigned CW    = (TIME_BITS > FIELD_W) ? TIME_BITS : FIELD_W;
  localparam int unsigned PW    = (TIME_BITS + 1 > FIELD_W) ? TIME_BITS + 1 : FIELD_W;
  localparam int unsigned MC_W  = $clog2(NUM_TASKS + 1);

  // Configuration.
  logic [NUM_TASKS-1:0] en;
  logic [FIELD_W-1:0]   per [NUM_TASKS];
  logic [FIELD_W-1:0]   exe [NUM_TASKS];
  logic [FIELD_W-1:0]   cnt [NUM_TASKS];

  rmts_cfg #(.NUM_TASKS(NUM_TASKS)) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .en_o        (en),
    .per_o       (per),
    .exe_o       (exe),
    .cnt_o       (cnt)
  );

  // Pipeline control.
  logic s1_vld_q, adv_q, out_vld_q;
  logic fire, in_acc;
  res_t res_q, res_d;

  assign fire       = s1_vld_q & (~out_vld_q | ~out_stall_i);
  assign in_stall_o = s1_vld_q & ~fire;
  assign in_acc     = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_vld_q <= 1'b1;
      end else if (fire) begin
        s1_vld_q <= 1'b0;
      end
      if (fire) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      adv_q <= advance_i;
    end
    if (fire) begin
      res_q <= res_d;
    end
  end

  // Task state.
  logic [TIME_BITS-1:0] phase_q [NUM_TASKS];
  logic [TIME_BITS-1:0] rem_q   [NUM_TASKS];
  logic [TIME_BITS-1:0] rel_q   [NUM_TASKS];
  logic [TIME_BITS-1:0] age_q   [NUM_TASKS];
  logic [TIME_BITS-1:0] phase_nx [NUM_TASKS];
  logic [TIME_BITS-1:0] rem_rel  [NUM_TASKS];
  logic [TIME_BITS-1:0] age_rel  [NUM_TASKS];
  logic [TIME_BITS-1:0] rem_nx   [NUM_TASKS];
  logic [TIME_BITS-1:0] rel_nx   [NUM_TASKS];
  logic [TIME_BITS-1:0] age_nx   [NUM_TASKS];
  logic [FIELD_W-1:0]   wait_sat [NUM_TASKS];

  logic [NUM_TASKS-1:0] miss, rls, ready, gnt, fin_vec, pre_vec, done_vec;

  logic [RUN_W-1:0]   lr_q;
  logic               lrv_q;
  logic [FIELD_W-1:0] cmp_q, mc_q;

  logic             found;
  logic [IDX_W-1:0] pick_idx;

  for (genvar i = 0; i < NUM_TASKS; i++) begin : g_task
    logic bnd, lr_hit;

    // A period boundary drops an unfinished job and releases the next one while the job count is not reached.
    assign bnd    = adv_q & en[i] & (phase_q[i] == '0);
    assign miss[i] = bnd & (rem_q[i] != '0);
    assign rls[i]  = bnd & (CW'(rel_q[i]) < CW'(cnt[i]));

    assign rem_rel[i] = rls[i] ? TIME_BITS'(exe[i]) : (miss[i] ? '0 : rem_q[i]);
    assign age_rel[i] = rls[i] ? '0 : age_q[i];
    assign rel_nx[i]  = rls[i] ? rel_q[i] + 1'b1 : rel_q[i];

    always_comb begin
      phase_nx[i] = phase_q[i];
      if (adv_q && en[i]) begin
        if (PW'(phase_q[i]) + PW'(1) >= PW'(per[i])) begin
          phase_nx[i] = '0;
        end else begin
          phase_nx[i] = phase_q[i] + 1'b1;
        end
      end
    end

    assign ready[i] = en[i] & (rem_rel[i] != '0);
    assign gnt[i]   = adv_q & found & (pick_idx == IDX_W'(i));

    assign rem_nx[i] = gnt[i] ? rem_rel[i] - 1'b1 : rem_rel[i];
    assign age_nx[i] = (adv_q & ready[i] & ~gnt[i] & ~(&age_rel[i])) ?
                       age_rel[i] + 1'b1 : age_rel[i];

    assign fin_vec[i]  = gnt[i] & (rem_rel[i] == TIME_BITS'(1));
    assign wait_sat[i] = (CW'(age_rel[i]) > CW'(SAT_MAX)) ? SAT_MAX : FIELD_W'(age_rel[i]);

    assign lr_hit     = (i < (1 << RUN_W)) && (int'(lr_q) == i);
    assign pre_vec[i] = adv_q & lrv_q & lr_hit & en[i] & ~miss[i] &
                        (rem_rel[i] != '0) & ~gnt[i];

    assign done_vec[i] = ~en[i] | ((CW'(rel_nx[i]) >= CW'(cnt[i])) & (rem_nx[i] == '0));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        phase_q[i] <= '0;
        rem_q[i]   <= '0;
        rel_q[i]   <= '0;
        age_q[i]   <= '0;
      end else if (fire) begin
        phase_q[i] <= phase_nx[i];
        rem_q[i]   <= rem_nx[i];
        rel_q[i]   <= rel_nx[i];
        age_q[i]   <= age_nx[i];
      end
    end
  end

  rmts_pick #(.NUM_TASKS(NUM_TASKS)) u_pick (
    .ready_i (ready),
    .per_i   (per),
    .found_o (found),
    .idx_o   (pick_idx)
  );

  // Shared counters and result.
  logic               fin;
  logic [FIELD_W-1:0] fwait;
  logic [MASK_W-1:0]  mmask;
  logic [MC_W-1:0]    n_miss;
  logic [FIELD_W:0]   mc_sum;
  logic [FIELD_W-1:0] mc_d, cmp_d;
  logic [RUN_W-1:0]   lr_d;
  logic               lrv_d;

  assign fin    = |fin_vec;
  assign n_miss = MC_W'($countones(miss));
  assign mc_sum = (FIELD_W+1)'(mc_q) + (FIELD_W+1)'(n_miss);
  assign mc_d   = mc_sum[FIELD_W] ? SAT_MAX : mc_sum[FIELD_W-1:0];
  assign cmp_d  = (fin && cmp_q != SAT_MAX) ? cmp_q + 1'b1 : cmp_q;

  always_comb begin
    fwait = '0;
    for (int i = 0; i < NUM_TASKS; i++) begin
      if (fin_vec[i]) begin
        fwait = wait_sat[i];
      end
    end
    for (int b = 0; b < MASK_W; b++) begin
      mmask[b] = (b < NUM_TASKS) ? miss[b] : 1'b0;
    end
  end

  always_comb begin
    lr_d  = lr_q;
    lrv_d = lrv_q;
    if (adv_q) begin
      lrv_d = found & ~fin;
      if (found) begin
        lr_d = RUN_W'(pick_idx);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lr_q  <= '0;
      lrv_q <= 1'b0;
      cmp_q <= '0;
      mc_q  <= '0;
    end else if (fire) begin
      lr_q  <= lr_d;
      lrv_q <= lrv_d;
      cmp_q <= cmp_d;
      mc_q  <= mc_d;
    end
  end

  always_comb begin
    res_d.running_task      = found ? RUN_W'(pick_idx) : '0;
    res_d.cpu_idle          = ~found;
    res_d.preempted         = |pre_vec;
    res_d.finished          = fin;
    res_d.finished_wait     = fwait;
    res_d.missed_mask       = mmask;
    res_d.all_done          = &done_vec;
    res_d.completions_total = cmp_d;
    res_d.misses_total      = mc_d;
  end

  assign out_valid_o         = out_vld_q;
  assign running_task_o      = res_q.running_task;
  assign cpu_idle_o          = res_q.cpu_idle;
  assign preempted_o         = res_q.preempted;
  assign finished_o          = res_q.finished;
  assign finished_wait_o     = res_q.finished_wait;
  assign missed_mask_o       = res_q.missed_mask;
  assign all_done_o          = res_q.all_done;
  assign completions_total_o = res_q.completions_total;
  assign misses_total_o      = res_q.misses_total;

endmodule

[hdl/rmts_checker.sv]
`include "rate_monotonic_tick_scheduler_top_defines.svh"

module rmts_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            cfg_valid_i,
  input logic                            cfg_ready_o,
  input logic [rmts_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input logic [rmts_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input logic                            in_valid_i,
  input logic                            in_stall_o,
  input logic                            advance_i,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic [rmts_pkg::RUN_W-1:0]      running_task_o,
  input logic                            cpu_idle_o,
  input logic                            preempted_o,
  input logic                            finished_o,
  input logic [rmts_pkg::FIELD_W-1:0]    finished_wait_o,
  input logic [rmts_pkg::MASK_W-1:0]     missed_mask_o,
  input logic                            all_done_o,
  input logic [rmts_pkg::FIELD_W-1:0]    completions_total_o,
  input logic [rmts_pkg::FIELD_W-1:0]    misses_total_o
);
  import rmts_pkg::*;

  logic unused_ok;
  assign unused_ok = cfg_valid_i ^ cfg_ready_o ^ (^cfg_index_i) ^ (^cfg_data_i) ^
                     in_valid_i ^ in_stall_o ^ advance_i;

  // An idle processor reports task zero.
  `RMTS_ASSERT_IMPL(a_idle_task, clk_i, rst_ni, out_valid_o && cpu_idle_o, running_task_o == '0)

  // A waiting time is only shown together with a finished job.
  `RMTS_ASSERT_IMPL(a_wait_fin, clk_i, rst_ni, out_valid_o && !finished_o, finished_wait_o == '0)

  // Preemption and completion both need a granted task.
  `RMTS_ASSERT_IMPL(a_pre_busy, clk_i, rst_ni, out_valid_o && (preempted_o || finished_o), !cpu_idle_o)

  // A stalled result stays in place, totals included.
  `RMTS_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(completions_total_o) && $stable(misses_total_o) && $stable(missed_mask_o) && $stable(all_done_o) && $stable(running_task_o))

endmodule

bind rate_monotonic_tick_scheduler_top rmts_checker u_rmts_checker (.*);
